/* rtl/swfd_pkg.sv */
// ----------------------------------------------------------------------------
// swfd_pkg
// Shared types and constants for the sync word frame deframer.
// ----------------------------------------------------------------------------
package swfd_pkg;

  // The first three sync bytes sit in the history register, newest in the low byte.
  localparam logic [23:0] SYNC_HEAD = 24'h404D44;
  localparam logic [7:0]  SYNC_LAST = 8'h78;

  // Width of the byte position counter within a frame.
  localparam int unsigned IDX_W = 17;

  // Header byte positions, counted from the first sync byte.
  localparam logic [IDX_W-1:0] FIRST_HDR_POS = 17'd4;
  localparam logic [IDX_W-1:0] TYPE_POS      = 17'd6;
  localparam logic [IDX_W-1:0] STATUS_POS    = 17'd8;
  localparam logic [IDX_W-1:0] SEQ_POS       = 17'd10;
  localparam logic [IDX_W-1:0] SEQ_POS_HI    = 17'd11;
  localparam logic [IDX_W-1:0] LEN_POS       = 17'd14;
  localparam logic [IDX_W-1:0] LEN_POS_HI    = 17'd15;
  localparam logic [IDX_W-1:0] HDR_LEN       = 17'd16;
  localparam logic [IDX_W-1:0] FRAME_OVERHEAD = 17'd18;

  // A sync word is wholly inside the payload once its last byte is at least here.
  localparam logic [IDX_W-1:0] PAY_SYNC_MIN = 17'd19;

  // Largest position reachable: last trailer byte of a maximum length frame.
  localparam logic [IDX_W-1:0] MAX_POS = 17'd65552;

  localparam logic [7:0] TYPE_ACK  = 8'h02;
  localparam logic [7:0] STATUS_OK = 8'h00;

  // One completed frame record.
  typedef struct packed {
    logic [15:0] seq_number;
    logic [15:0] payload_length;
    logic [7:0]  frame_type;
    logic [7:0]  status_byte;
    logic        ack_ok;
  } swfd_record_t;

endpackage

/* rtl/swfd_sync_det.sv */
// ----------------------------------------------------------------------------
// swfd_sync_det
// Sliding three-byte history and sync word match on the incoming byte.
// ----------------------------------------------------------------------------
module swfd_sync_det
  import swfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       beat,
  input  logic [7:0] rx_byte,
  input  logic       clear,
  output logic       sync
);

  logic [23:0] recent_bytes;

  // The sync word completes when the history holds the head and this byte is the tail.
  assign sync = (recent_bytes == SYNC_HEAD) && (rx_byte == SYNC_LAST);

  // Shift in every accepted byte; the end of a frame wipes the history.
  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes <= '0;
    end else if (beat) begin
      if (clear) begin
        recent_bytes <= '0;
      end else begin
        recent_bytes <= {recent_bytes[15:0], rx_byte};
      end
    end
  end

endmodule

/* rtl/swfd_hdr_parse.sv */
// ----------------------------------------------------------------------------
// swfd_hdr_parse
// Frame position tracking, header field capture and frame end detection.
// ----------------------------------------------------------------------------
module swfd_hdr_parse
  import swfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic         cfg_data,
  input  logic         beat,
  input  logic [7:0]   rx_byte,
  input  logic         sync,
  output logic         emit,
  output swfd_record_t record
);

  logic             length_big_endian;
  logic             in_frame;
  logic [IDX_W-1:0] byte_index;
  logic [7:0]       held_type;
  logic [7:0]       held_status;
  logic [7:0]       seq_first;
  logic [15:0]      held_sequence;
  logic [7:0]       len_first;
  logic [15:0]      held_length;
  logic [IDX_W-1:0] pay_end;
  logic [IDX_W-1:0] frame_end;

  logic [15:0]      seq_join;
  logic [15:0]      len_join;
  logic             restart;
  logic             at_len_hi;

  // Byte order of the 16-bit fields is sampled on their second byte.
  assign seq_join = length_big_endian ? {seq_first, rx_byte} : {rx_byte, seq_first};
  assign len_join = length_big_endian ? {len_first, rx_byte} : {rx_byte, len_first};

  // A sync word lying wholly inside the payload drops the frame.
  assign restart = in_frame && sync && (byte_index >= PAY_SYNC_MIN) && (byte_index < pay_end);

  // The last trailer byte closes the frame.
  assign emit = in_frame && (byte_index >= HDR_LEN) && (byte_index == frame_end);

  assign at_len_hi = in_frame && (byte_index == LEN_POS_HI);

  // Result record from the held header fields.
  always_comb begin
    record.seq_number     = held_sequence;
    record.payload_length = held_length;
    record.frame_type     = held_type;
    record.status_byte    = held_status;
    record.ack_ok         = (held_type == TYPE_ACK) && (held_status == STATUS_OK);
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      length_big_endian <= 1'b0;
    end else if (cfg_write) begin
      length_big_endian <= cfg_data;
    end
  end

  // Hunt and frame position control.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_index <= '0;
    end else if (beat) begin
      priority if (!in_frame) begin
        if (sync) begin
          in_frame   <= 1'b1;
          byte_index <= FIRST_HDR_POS;
        end
      end else if (restart) begin
        byte_index <= FIRST_HDR_POS;
      end else if (emit) begin
        in_frame   <= 1'b0;
        byte_index <= '0;
      end else begin
        byte_index <= byte_index + 17'd1;
      end
    end
  end

  // Header field capture; the frame bounds follow from the length field.
  always_ff @(posedge clk) begin
    if (beat && in_frame) begin
      if (byte_index == TYPE_POS) begin
        held_type <= rx_byte;
      end
      if (byte_index == STATUS_POS) begin
        held_status <= rx_byte;
      end
      if (byte_index == SEQ_POS) begin
        seq_first <= rx_byte;
      end
      if (byte_index == SEQ_POS_HI) begin
        held_sequence <= seq_join;
      end
      if (byte_index == LEN_POS) begin
        len_first <= rx_byte;
      end
      if (at_len_hi) begin
        held_length <= len_join;
        pay_end     <= {1'b0, len_join} + HDR_LEN;
        frame_end   <= {1'b0, len_join} + FRAME_OVERHEAD - 17'd1;
      end
    end
  end

  // Hunting always keeps the position counter at zero.
  a_hunt_idle : assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> byte_index == '0)
    else $error("byte position not zero while hunting");

  // Inside a frame the position stays between the first header byte and the longest frame.
  a_idx_range : assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (byte_index >= FIRST_HDR_POS) && (byte_index <= MAX_POS))
    else $error("byte position out of frame range");

  // A frame record ends the frame.
  a_emit_ends : assert property (@(posedge clk) disable iff (rst)
    (beat && emit) |=> !in_frame)
    else $error("frame still open after its record");

  // A restart and a frame end never fall on the same byte.
  a_excl : assert property (@(posedge clk) disable iff (rst)
    !(restart && emit))
    else $error("restart and frame end together");

endmodule

/* rtl/swfd_out_reg.sv */
// ----------------------------------------------------------------------------
// swfd_out_reg
// Result register with one spare slot, so that a record waiting for the sink
// does not hold up the byte input.
// ----------------------------------------------------------------------------
module swfd_out_reg
  import swfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  swfd_record_t record,
  output logic         space,
  output logic         out_valid,
  input  logic         out_ready,
  output swfd_record_t held
);

  logic         spare_valid;
  swfd_record_t spare;

  // A new beat may enter while the spare slot is free.
  assign space = !spare_valid;

  // Valid flags. A record that arrives while the output slot is held waits in the spare slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (load) begin
        spare_valid <= 1'b1;
      end
    end else begin
      out_valid   <= spare_valid || load;
      spare_valid <= 1'b0;
    end
  end

  // Payload. The spare record moves up before any new one is taken.
  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (load) begin
        spare <= record;
      end
    end else if (spare_valid) begin
      held <= spare;
    end else if (load) begin
      held <= record;
    end
  end

  // The spare slot is only used behind a waiting output record.
  a_spare_behind : assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> out_valid)
    else $error("spare record without an output record");

  // No record arrives while both slots are full.
  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    !(load && spare_valid))
    else $error("record lost on a full result buffer");

  // An output record stays until the sink takes it.
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output record dropped before it was taken");

endmodule

/* rtl/sync_word_frame_deframer.sv */
// ----------------------------------------------------------------------------
// sync_word_frame_deframer
// Finds sync words in a byte stream, captures the frame header and emits one
// record per completed frame.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Beat contents
// input     in         in_valid / in_ready    rx_byte
// output    out        out_valid / out_ready  seq_number, payload_length,
//                                             frame_type, status_byte, ack_ok
// config    in         cfg_write              cfg_data (length_big_endian)
//
// One byte is taken per clock; each byte is fully handled in the cycle it is
// accepted, and a frame record is valid on the output from the cycle after the
// last trailer byte when the output register is free. A second record waits in
// a spare register behind the first; in_ready is low only while both hold a
// record, and it does not depend on out_ready in the same cycle. Synchronous
// reset clears the hunt state, the byte history and both valid flags.
// ----------------------------------------------------------------------------
module sync_word_frame_deframer
  import swfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] seq_number,
  output logic [15:0] payload_length,
  output logic [7:0]  frame_type,
  output logic [7:0]  status_byte,
  output logic        ack_ok
);

  logic         beat;
  logic         sync;
  logic         emit;
  logic         space;
  swfd_record_t record;
  swfd_record_t held;

  assign in_ready = space;
  assign beat     = in_valid && space;

  // Sync word search over the byte history.
  swfd_sync_det u_sync (
    .clk     (clk),
    .rst     (rst),
    .beat    (beat),
    .rx_byte (rx_byte),
    .clear   (emit),
    .sync    (sync)
  );

  // Frame position and header capture.
  swfd_hdr_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .beat      (beat),
    .rx_byte   (rx_byte),
    .sync      (sync),
    .emit      (emit),
    .record    (record)
  );

  // Result register.
  swfd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (beat && emit),
    .record    (record),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign seq_number     = held.seq_number;
  assign payload_length = held.payload_length;
  assign frame_type     = held.frame_type;
  assign status_byte    = held.status_byte;
  assign ack_ok         = held.ack_ok;

endmodule

/* dv/swfd_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfd_frame_checker
// Watches the byte, record and configuration ports of the deframer, runs its
// own frame parser on every accepted byte beat and compares each record beat,
// field by field, with the oldest record that the parser has produced.
// ----------------------------------------------------------------------------
module swfd_frame_checker
  import swfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] seq_number,
  input  logic [15:0] payload_length,
  input  logic [7:0]  frame_type,
  input  logic [7:0]  status_byte,
  input  logic        ack_ok,
  output int          pending,
  output int          fail_count
);

  // Parser state, mirroring what the block keeps between bytes.
  logic             big_endian;
  logic             in_frame;
  logic [IDX_W-1:0] frame_pos;
  logic [23:0]      recent;
  logic [7:0]       held_type;
  logic [7:0]       held_status;
  logic [15:0]      held_seq;
  logic [15:0]      held_len;

  // Frame records still owed by the block, oldest first.
  swfd_record_t expected_records[$];

  // Joins the two bytes of a 16-bit header field in the current byte order.
  function automatic logic [15:0] order16(input logic [7:0] first, input logic [7:0] second);
    return big_endian ? {first, second} : {second, first};
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // Advances the parser by one received byte and queues a record when a frame ends.
  task automatic parse_byte(input logic [7:0] b);
    logic             sync_hit;
    logic [IDX_W-1:0] pos;
    swfd_record_t     rec;
    sync_hit = (recent == SYNC_HEAD) && (b == SYNC_LAST);
    pos      = frame_pos;
    recent   = {recent[15:0], b};
    if (!in_frame) begin
      if (sync_hit) begin
        in_frame  = 1'b1;
        frame_pos = FIRST_HDR_POS;
      end
    end else begin
      // Header capture; the byte order is taken when the second byte arrives.
      case (pos)
        TYPE_POS:   held_type   = b;
        STATUS_POS: held_status = b;
        SEQ_POS:    held_seq    = {8'h00, b};
        SEQ_POS_HI: held_seq    = order16(held_seq[7:0], b);
        LEN_POS:    held_len    = {8'h00, b};
        LEN_POS_HI: held_len    = order16(held_len[7:0], b);
        default: ;
      endcase
      if (sync_hit && pos >= PAY_SYNC_MIN && pos < HDR_LEN + {1'b0, held_len}) begin
        // A sync word wholly inside the payload drops the frame and starts a new one.
        frame_pos = FIRST_HDR_POS;
      end else if (pos >= HDR_LEN && pos == {1'b0, held_len} + FRAME_OVERHEAD - 1) begin
        rec.seq_number     = held_seq;
        rec.payload_length = held_len;
        rec.frame_type     = held_type;
        rec.status_byte    = held_status;
        rec.ack_ok         = (held_type == TYPE_ACK) && (held_status == STATUS_OK);
        expected_records = {expected_records, rec};
        in_frame  = 1'b0;
        frame_pos = '0;
        recent    = '0;
      end else begin
        frame_pos = pos + 1'b1;
      end
    end
  endtask

  // Compare record beats, then feed byte beats and register writes to the parser.
  always @(posedge clk) begin
    swfd_record_t want;
    if (rst) begin
      big_endian  = 1'b0;
      in_frame    = 1'b0;
      frame_pos   = '0;
      recent      = '0;
      held_type   = '0;
      held_status = '0;
      held_seq    = '0;
      held_len    = '0;
      expected_records.delete();
      pending     = 0;
      fail_count  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_records.size() == 0) begin
          report_mismatch("record with none expected, seq_number", seq_number, 16'h0);
        end else begin
          want = expected_records[0];
          expected_records.delete(0);
          if (seq_number !== want.seq_number)
            report_mismatch("seq_number", seq_number, want.seq_number);
          if (payload_length !== want.payload_length)
            report_mismatch("payload_length", payload_length, want.payload_length);
          if (frame_type !== want.frame_type)
            report_mismatch("frame_type", {8'h00, frame_type}, {8'h00, want.frame_type});
          if (status_byte !== want.status_byte)
            report_mismatch("status_byte", {8'h00, status_byte}, {8'h00, want.status_byte});
          if (ack_ok !== want.ack_ok)
            report_mismatch("ack_ok", {15'h0, ack_ok}, {15'h0, want.ack_ok});
        end
      end
      if (in_valid && in_ready)
        parse_byte(rx_byte);
      if (cfg_write)
        big_endian = cfg_data;
      pending = expected_records.size();
    end
  end

endmodule

/* dv/tb_sync_word_frame_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_word_frame_deframer
// Drives byte streams into the deframer: a directed set of frames covering
// overlapping sync prefixes, sync words in header, payload and trailer, byte
// order switches between field bytes and the field extremes, then random
// frames, broken frames and noise in both byte orders. A checker module beside
// the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_sync_word_frame_deframer
  import swfd_pkg::*;
();

  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASE_BYTES = 330;
  localparam int LONG_HOLD   = 400;
  localparam int NO_SPLIT    = 0;

  localparam logic [7:0] TYPE_REPLY  = 8'h03;
  localparam logic [7:0] TYPE_NOTIFY = 8'h04;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] seq_number;
  logic [15:0] payload_length;
  logic [7:0]  frame_type;
  logic [7:0]  status_byte;
  logic        ack_ok;

  int pending;
  int fail_count;
  int cycle_count = 0;

  // Sender bookkeeping.
  logic cfg_be      = 1'b0;
  int   burst_left  = 0;
  int   frame_bytes = 0;
  bit   hold_req    = 1'b0;

  sync_word_frame_deframer i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .seq_number     (seq_number),
    .payload_length (payload_length),
    .frame_type     (frame_type),
    .status_byte    (status_byte),
    .ack_ok         (ack_ok)
  );

  swfd_frame_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .seq_number     (seq_number),
    .payload_length (payload_length),
    .frame_type     (frame_type),
    .status_byte    (status_byte),
    .ack_ok         (ack_ok),
    .pending        (pending),
    .fail_count     (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_sync_word_frame_deframer NOT OK");
    $finish;
  end

  // Receiver: epochs of random stall density, plus one long hold-off on request.
  initial begin : receiver
    int span;
    int stall_pct;
    int hold_left;
    bit hold_done;
    out_ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      span = $urandom_range(20, 200);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      repeat (span) begin
        if (hold_req && !hold_done) begin
          hold_done = 1'b1;
          hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
        @(negedge clk);
      end
    end
  end

  // Offers one byte beat and returns at the falling edge after it is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Holds the sender until every owed record has come out, then lets the block settle.
  task automatic wait_idle();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_byte_order(input logic big);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= big;
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_be     = big;
  endtask

  // Sends a sync word, the header, pay_count payload bytes and optionally the
  // trailer. The byte order register is flipped just before header byte
  // split_at; 16-bit fields are encoded in the order in force at the start.
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] fstatus,
                            input logic [15:0] seq, input logic [15:0] len,
                            input int pay_count, input bit with_trailer,
                            input int split_at);
    logic [7:0] hdr [4:15];
    for (int p = 4; p <= 15; p++) hdr[p] = 8'($urandom_range(0, 255));
    hdr[TYPE_POS]   = ftype;
    hdr[STATUS_POS] = fstatus;
    hdr[SEQ_POS]    = cfg_be ? seq[15:8] : seq[7:0];
    hdr[SEQ_POS_HI] = cfg_be ? seq[7:0]  : seq[15:8];
    hdr[LEN_POS]    = cfg_be ? len[15:8] : len[7:0];
    hdr[LEN_POS_HI] = cfg_be ? len[7:0]  : len[15:8];
    // With this type the header carries a complete sync word at bytes 4 to 7.
    if (ftype == SYNC_HEAD[7:0]) begin
      hdr[4] = SYNC_HEAD[23:16];
      hdr[5] = SYNC_HEAD[15:8];
      hdr[7] = SYNC_LAST;
    end
    send_byte(SYNC_HEAD[23:16]);
    send_byte(SYNC_HEAD[15:8]);
    send_byte(SYNC_HEAD[7:0]);
    send_byte(SYNC_LAST);
    for (int p = 4; p <= 15; p++) begin
      if (p == split_at) set_byte_order(!cfg_be);
      send_byte(hdr[p]);
    end
    for (int i = 0; i < pay_count; i++) send_byte(8'($urandom_range(0, 255)));
    if (with_trailer) begin
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end
    frame_bytes += HDR_LEN + pay_count + (with_trailer ? 2 : 0);
  endtask

  task automatic send_random_frame(input logic [15:0] len, input int pay_count,
                                   input bit with_trailer);
    logic [7:0] ftype;
    logic [7:0] fstatus;
    case ($urandom_range(0, 5))
      0, 1:    ftype = TYPE_ACK;
      2:       ftype = TYPE_REPLY;
      3:       ftype = TYPE_NOTIFY;
      4:       ftype = SYNC_HEAD[7:0];
      default: ftype = 8'($urandom_range(0, 255));
    endcase
    fstatus = ($urandom_range(0, 1) == 0) ? STATUS_OK : 8'($urandom_range(0, 255));
    send_frame(ftype, fstatus, 16'($urandom_range(0, 65535)), len, pay_count, with_trailer,
               NO_SPLIT);
  endtask

  initial begin : stimulus
    int pick;
    int len;
    int cut;
    int target;
    rst       = 1'b1;
    in_valid  = 1'b0;
    rx_byte   = 8'h00;
    cfg_write = 1'b0;
    cfg_data  = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Overlapping sync prefix ahead of a zero-length ack with good status.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_HEAD[23:16]);
    send_byte(SYNC_HEAD[15:8]);
    send_byte(SYNC_HEAD[7:0]);
    send_frame(TYPE_ACK, STATUS_OK, 16'h0000, 16'h0000, 0, 1'b1, NO_SPLIT);
    send_frame(TYPE_ACK, 8'h01, 16'hFFFF, 16'h0003, 3, 1'b1, NO_SPLIT);
    send_frame(TYPE_REPLY, 8'hFF, 16'h8001, 16'h0001, 1, 1'b1, NO_SPLIT);
    // A sync word inside the header is ordinary data.
    send_frame(SYNC_HEAD[7:0], STATUS_OK, 16'h00FF, 16'h0002, 2, 1'b1, NO_SPLIT);
    // Longest declared frame, dropped by a sync word at the very start of its payload.
    send_frame(TYPE_NOTIFY, 8'h80, 16'h7FFF, 16'hFFFF, 0, 1'b0, NO_SPLIT);
    // A sync word ending on the last payload byte still restarts the frame.
    send_frame(TYPE_NOTIFY, STATUS_OK, 16'h0102, 16'h0007, 3, 1'b0, NO_SPLIT);
    send_frame(TYPE_ACK, STATUS_OK, 16'h0201, 16'h0000, 0, 1'b1, NO_SPLIT);
    // A sync word ending on the first trailer byte does not; the frame completes.
    send_frame(TYPE_REPLY, 8'h7F, 16'hFF00, 16'h0006, 3, 1'b0, NO_SPLIT);
    send_byte(SYNC_HEAD[23:16]);
    send_byte(SYNC_HEAD[15:8]);
    send_byte(SYNC_HEAD[7:0]);
    send_byte(SYNC_LAST);
    send_byte(8'($urandom_range(0, 255)));
    // Byte order switched between the two sequence bytes.
    send_frame(TYPE_ACK, STATUS_OK, 16'h12AB, 16'h0002, 2, 1'b1, SEQ_POS_HI);
    // Switched back between the length bytes: 0x0100 sent high first reads as 1.
    send_frame(TYPE_REPLY, STATUS_OK, 16'h5AA5, 16'h0100, 1, 1'b1, LEN_POS_HI);
    set_byte_order(1'b1);
    send_frame(TYPE_ACK, STATUS_OK, 16'hA55A, 16'h0102, 258, 1'b1, NO_SPLIT);

    // Random phases, alternating the byte order at each idle point.
    for (int ph = 0; ph < 4; ph++) begin
      set_byte_order(ph % 2 == 0);
      if (ph == 1) hold_req = 1'b1;
      target = frame_bytes + PHASE_BYTES;
      while (frame_bytes < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 24) : $urandom_range(25, 120);
          send_random_frame(16'(len), len, 1'b1);
        end else if (pick < 72) begin
          // The next frame's sync word lands wholly inside this payload.
          len = $urandom_range(4, 65535);
          cut = $urandom_range(0, (len - 4 < 20) ? len - 4 : 20);
          send_random_frame(16'(len), cut, 1'b0);
          len = $urandom_range(0, 24);
          send_random_frame(16'(len), len, 1'b1);
        end else if (pick < 80) begin
          // Sync word straddling the payload end and the trailer.
          len = $urandom_range(3, 24);
          send_random_frame(16'(len), len - 3, 1'b0);
          send_byte(SYNC_HEAD[23:16]);
          send_byte(SYNC_HEAD[15:8]);
          send_byte(SYNC_HEAD[7:0]);
          send_byte(SYNC_LAST);
          send_byte(8'($urandom_range(0, 255)));
          frame_bytes += 5;
        end else if (pick < 92) begin
          // Line noise, sometimes ending in a partial sync word.
          repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 2) == 0) begin
            send_byte(SYNC_HEAD[23:16]);
            send_byte(SYNC_HEAD[15:8]);
            if ($urandom_range(0, 1) == 0) send_byte(SYNC_HEAD[7:0]);
          end
        end else begin
          // Frame cut short; whatever follows is parsed as its remainder.
          len = $urandom_range(0, 24);
          cut = $urandom_range(0, len);
          send_random_frame(16'(len), cut, 1'b0);
        end
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_sync_word_frame_deframer OK");
    end else begin
      $display("tb_sync_word_frame_deframer NOT OK");
    end
    $finish;
  end

endmodule
